// ----- design/shs_pkg.sv -----
// Shared types, constants and the half-step coil table for the stepper sequencer.
package shs_pkg;

  localparam int unsigned TICK_W  = 20;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned COIL_W  = 4;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX  = 2'd2;

  localparam logic [TICK_W-1:0] TICK_RATE_RST = 20'd250000;
  localparam logic [RATE_W-1:0] RATE_MIN_RST  = 16'd1;
  localparam logic [RATE_W-1:0] RATE_MAX_RST  = 16'd1000;

  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } shs_div_stat_t;

  function automatic logic [COIL_W-1:0] phase_coils(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'd1;
      3'd1:    pat = 4'd3;
      3'd2:    pat = 4'd2;
      3'd3:    pat = 4'd6;
      3'd4:    pat = 4'd4;
      3'd5:    pat = 4'd12;
      3'd6:    pat = 4'd8;
      3'd7:    pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

// ----- design/shs_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module shs_div import shs_pkg::*; #(
  parameter int unsigned DVD_W = TICK_W,
  parameter int unsigned DVS_W = RATE_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output shs_div_stat_t    stat_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             qbit;

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign qbit   = ~diff[DVS_W];
  assign rem_d  = qbit ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DVD_W - 1);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = dvd_q;

endmodule

// ----- design/stepper_half_step_sequencer.sv -----
// Half-step sequencer top level: command decode, phase walk and result register.
// A tick, stop or ignored command goes from idle to the execute state, which
// registers its result once the output is free. A move from idle first passes through
// the divide state, where the bit-serial divider forms the hold period, one quotient bit per cycle.
// Commands are taken only while idle, so a new one waits until the last result is registered.
// Reset (async, active low) restores the register defaults and turns all coils off.
module stepper_half_step_sequencer import shs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TICK_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // step_count[15:0], step_rate[31:16]
  input  logic [OP_W-1:0]      s_axis_tuser,  // op[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata   // coils[3:0], busy_res[4], done_res[5]
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]         state_q;
  logic [TICK_W-1:0]  tick_rate_q;
  logic [RATE_W-1:0]  rate_min_q;
  logic [RATE_W-1:0]  rate_max_q;

  logic [OP_W-1:0]    op_q;
  logic [COUNT_W-1:0] cnt_q;

  logic [COUNT_W-1:0] steps_q;
  logic               reverse_q;
  logic [PHASE_W-1:0] phase_q;
  logic [HOLD_W-1:0]  hold_q;
  logic [HOLD_W-1:0]  tick_q;
  logic               moving_q;
  logic [COIL_W-1:0]  coils_q;

  logic               m_valid_q;
  logic [7:0]         m_data_q;

  logic               accept;
  logic               div_start;
  logic [RATE_W-1:0]  req;
  logic [RATE_W-1:0]  rate_lo;
  logic [RATE_W-1:0]  rate_clamp;
  shs_div_stat_t      div_stat;
  logic [TICK_W-1:0]  quot;
  logic [HOLD_W-1:0]  hold_calc;
  logic               out_free;
  logic               exec_fire;
  logic [PHASE_W-1:0] phase_d;
  logic               neg;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign div_start     = accept & (s_axis_tuser == OP_MOVE) & ~moving_q;

  assign req        = s_axis_tdata[31:16];
  assign rate_lo    = (req < rate_min_q) ? rate_min_q : req;
  assign rate_clamp = (rate_lo > rate_max_q) ? rate_max_q : rate_lo;

  shs_div #(
    .DVD_W (TICK_W),
    .DVS_W (RATE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tick_rate_q),
    .divisor_i  (rate_clamp),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  assign hold_calc = (quot == '0) ? '0 :
                     (quot > TICK_W'(HOLD_MAX) + 1'b1) ? HOLD_MAX :
                     HOLD_W'(quot - 1'b1);

  assign out_free  = ~m_valid_q | m_axis_tready;
  assign exec_fire = (state_q == ST_EXEC) & out_free;
  assign phase_d   = reverse_q ? phase_q - 1'b1 : phase_q + 1'b1;
  assign neg       = cnt_q[COUNT_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= TICK_RATE_RST;
      rate_min_q  <= RATE_MIN_RST;
      rate_max_q  <= RATE_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICK_RATE: tick_rate_q <= cfg_data_i;
        CFG_RATE_MIN:  rate_min_q  <= cfg_data_i[RATE_W-1:0];
        CFG_RATE_MAX:  rate_max_q  <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser;
      cnt_q <= s_axis_tdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) state_q <= div_start ? ST_DIV : ST_EXEC;
        end
        ST_DIV: begin
          if (div_stat.done) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q   <= '0;
      reverse_q <= 1'b0;
      phase_q   <= '0;
      hold_q    <= '0;
      tick_q    <= '0;
      moving_q  <= 1'b0;
      coils_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (exec_fire) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {2'b00, 1'b0, moving_q, coils_q};
        case (op_q)
          OP_MOVE: begin
            if (!moving_q) begin
              steps_q   <= neg ? COUNT_W'(~cnt_q + 1'b1) : cnt_q;
              reverse_q <= ~neg & (cnt_q != '0);
              hold_q    <= hold_calc;
              tick_q    <= '0;
              phase_q   <= '0;
              coils_q   <= phase_coils('0);
              moving_q  <= 1'b1;
              m_data_q  <= {2'b00, 1'b0, 1'b1, phase_coils('0)};
            end
          end
          OP_STOP: begin
            moving_q <= 1'b0;
            steps_q  <= '0;
            tick_q   <= '0;
            coils_q  <= '0;
            m_data_q <= '0;
          end
          OP_TICK: begin
            if (moving_q) begin
              if (tick_q >= hold_q) begin
                tick_q <= '0;
                if (steps_q == '0) begin
                  moving_q <= 1'b0;
                  coils_q  <= '0;
                  m_data_q <= {2'b00, 1'b1, 1'b0, {COIL_W{1'b0}}};
                end else begin
                  steps_q  <= steps_q - 1'b1;
                  phase_q  <= phase_d;
                  coils_q  <= phase_coils(phase_d);
                  m_data_q <= {2'b00, 1'b0, 1'b1, phase_coils(phase_d)};
                end
              end else begin
                tick_q <= tick_q + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_data_q[5] && m_data_q[4]))
    else $error("done and busy set together");

  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == ST_DIV)
    else $error("divider running outside divide state");

  a_idle_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !moving_q |-> coils_q == '0)
    else $error("coils energized while idle");

  a_moving_coils_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> coils_q != '0)
    else $error("no coil energized during a move");

  a_exec_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && m_valid_q && !m_axis_tready) |=> state_q == ST_EXEC)
    else $error("result dropped while output stalled");

endmodule
